[src/easing_curve_generator_assert.svh]
// ----------------------------------------------------------------------------
// easing curve generator assertion macros
// shared property forms for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_GENERATOR_ASSERT_SVH
`define EASING_CURVE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ECG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("easing curve generator: same-cycle check failed");

// next-cycle implication
`define ECG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("easing curve generator: next-cycle check failed");

`endif

[src/ecg_pkg.sv]
// ----------------------------------------------------------------------------
// ecg_pkg
// shared types, constants and helpers of the easing curve generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecg_pkg;

  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WORK_BITS = 30;
  localparam int WORD_BITS = 40;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t W_ONE = 40'sd1073741824;
  localparam word_t W_HALF = 40'sd536870912;
  localparam word_t W_TWO = word_t'(W_ONE * 2);
  localparam word_t W_TEN = word_t'(W_ONE * 10);
  localparam word_t W_89 = word_t'(W_ONE * 89);
  localparam word_t BACK_C2 = 40'sd2786262860;
  localparam word_t BACK_C2P1 = 40'sd3860004684;

  // curve select codes
  localparam logic [3:0] MODE_LINEAR  = 4'd0;
  localparam logic [3:0] MODE_SINE    = 4'd1;
  localparam logic [3:0] MODE_QUAD    = 4'd2;
  localparam logic [3:0] MODE_CUBIC   = 4'd3;
  localparam logic [3:0] MODE_QUART   = 4'd4;
  localparam logic [3:0] MODE_QUINT   = 4'd5;
  localparam logic [3:0] MODE_EXPO    = 4'd6;
  localparam logic [3:0] MODE_CIRC    = 4'd7;
  localparam logic [3:0] MODE_BACK    = 4'd8;
  localparam logic [3:0] MODE_ELASTIC = 4'd9;
  localparam logic [3:0] MODE_BOUNCE  = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_EASING_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE_DURATION = 2'd1;

  typedef struct packed {
    logic        start;
    logic [31:0] rem;
    logic [WORD_BITS-1:0] num;
    logic [31:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [WORD_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [30:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] root;
  } sq_rsp_t;

  // quarter-wave sine polynomial coefficients, q30
  function automatic word_t sin_coef(logic [2:0] i);
    word_t c;
    case (i)
      3'd0:    c = 40'sd1686629713;
      3'd1:    c = 40'sd693598668;
      3'd2:    c = 40'sd85569306;
      3'd3:    c = 40'sd5026995;
      3'd4:    c = 40'sd172272;
      default: c = '0;
    endcase
    return c;
  endfunction

  // (ln 2)^k / k! for k = 1..7 at index k-1, q30
  function automatic word_t exp_coef(logic [2:0] i);
    word_t c;
    case (i)
      3'd0:    c = 40'sd744261118;
      3'd1:    c = 40'sd257941248;
      3'd2:    c = 40'sd59597083;
      3'd3:    c = 40'sd10327387;
      3'd4:    c = 40'sd1431680;
      3'd5:    c = 40'sd165394;
      3'd6:    c = 40'sd16377;
      default: c = '0;
    endcase
    return c;
  endfunction

  // halve, truncating toward zero
  function automatic word_t sdiv2(word_t a);
    word_t m;
    m = a[WORD_BITS-1] ? -a : a;
    m = m >>> 1;
    return a[WORD_BITS-1] ? -m : m;
  endfunction

endpackage

[src/ecg_mul.sv]
// ----------------------------------------------------------------------------
// ecg_mul
// shared registered q30 multiplier: sign-magnitude product shifted right 30
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_mul (
  input  logic          clk,
  input  ecg_pkg::word_t a,
  input  ecg_pkg::word_t b,
  output ecg_pkg::word_t p
);

  logic [ecg_pkg::WORD_BITS-1:0] ma_w;
  logic [ecg_pkg::WORD_BITS-1:0] mb_w;
  logic [65:0] prod;
  logic [35:0] m;
  logic neg;

  always_comb begin
    ma_w = a[ecg_pkg::WORD_BITS-1] ? -a : a;
    mb_w = b[ecg_pkg::WORD_BITS-1] ? -b : b;
    prod = ma_w[32:0] * mb_w[32:0];
    m    = prod[65:30];
    neg  = a[ecg_pkg::WORD_BITS-1] ^ b[ecg_pkg::WORD_BITS-1];
  end

  always_ff @(posedge clk) begin
    p <= neg ? -ecg_pkg::word_t'({4'b0, m}) : ecg_pkg::word_t'({4'b0, m});
  end

endmodule

[src/ecg_div.sv]
// ----------------------------------------------------------------------------
// ecg_div
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_div (
  input  logic              clk,
  input  logic              rst,
  input  ecg_pkg::div_req_t req,
  output ecg_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dv;
  logic [ecg_pkg::WORD_BITS-1:0] num;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    sh   = {rem, num[ecg_pkg::WORD_BITS-1]};
    ge   = sh >= {1'b0, dv};
    diff = sh - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= req.rem;
        num  <= req.num;
        dv   <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[31:0] : sh[31:0];
        num <= {num[ecg_pkg::WORD_BITS-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = num;

endmodule

[src/ecg_sqrt.sv]
// ----------------------------------------------------------------------------
// ecg_sqrt
// digit-by-digit floor square root of a q30 radicand, one digit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  ecg_pkg::sq_req_t req,
  output ecg_pkg::sq_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  k;
  logic [60:0] v;
  logic [60:0] res;
  logic [60:0] bitv;
  logic [60:0] trial;

  always_comb begin
    bitv  = 61'd1 << {k, 1'b0};
    trial = res + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        k    <= 5'd30;
        v    <= {req.radicand, 30'b0};
        res  <= '0;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        k <= k - 5'd1;
        if (k == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = res[30:0];

endmodule

[src/easing_curve_generator.sv]
// ----------------------------------------------------------------------------
// easing curve generator
// a time of 1.0 skips the time division
// throughput: one item at a time, the next accepted in the cycle after the
//   result is loaded; set by the 16-step time division, the shared q30
//   multiplier loops and the bit-serial square root
// reset: synchronous, clears elapsed time, mode 0 and duration 1000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "easing_curve_generator_assert.svh"

module easing_curve_generator (
  input  logic        clk,
  input  logic        rst,
  // input stream, tdata: time_step[31:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // result stream, tdata: progress[17:0], normalized_time[34:18], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ecg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_WRAP, S_NORM, S_NORM_WAIT, S_EASE,
    S_PW_MUL, S_PW_ACC, S_PW_END,
    S_SN_F2, S_SN_INIT, S_SN_MUL, S_SN_ACC, S_SN_LAST, S_SN_END, S_SINE_END,
    S_PX_INIT, S_PX_MUL, S_PX_ACC, S_PX_LAST, S_PX_END, S_EX_END,
    S_CI_MUL, S_CI_SQ, S_CI_WAIT,
    S_BK_SQ, S_BK_M, S_BK_K, S_BK_MUL, S_BK_END,
    S_BO_MUL, S_BO_END,
    S_EL_DIV, S_EL_D1, S_EL_D2, S_EL_D3, S_EL_FIX, S_EL_POW, S_EL_MUL, S_EL_END,
    S_ROUND, S_OUT
  } state_t;

  state_t state;
  state_t ret;            // return point of the sine and power sub-sequences

  // configuration and running time
  logic [3:0]  easing_mode;
  logic [31:0] cycle_duration;
  logic [32:0] elapsed;
  logic [16:0] t;         // normalised time, q1.16

  // working registers
  ecg_pkg::word_t acc;
  ecg_pkg::word_t aux;
  ecg_pkg::word_t arg;
  ecg_pkg::word_t sres;
  ecg_pkg::word_t pres;
  logic [30:0] ff;
  logic [1:0]  quad;
  logic [5:0]  pn;
  logic [2:0]  cnt;
  logic [1:0]  br;
  logic        el_neg;
  logic [17:0] rounded;

  // output register
  logic [17:0] out_prog;
  logic [16:0] out_norm;

  // shared units
  ecg_pkg::word_t mul_a;
  ecg_pkg::word_t mul_b;
  ecg_pkg::word_t prod;
  ecg_pkg::div_req_t div_req;
  ecg_pkg::div_rsp_t div_rsp;
  ecg_pkg::sq_req_t  sq_req;
  ecg_pkg::sq_rsp_t  sq_rsp;

  ecg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  ecg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  ecg_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .rsp(sq_rsp));

  // derived time values
  logic [31:0] dur_eff;
  logic [33:0] sum;
  ecg_pkg::word_t x;
  ecg_pkg::word_t v;
  ecg_pkg::word_t u;
  ecg_pkg::word_t base;
  ecg_pkg::word_t y;
  ecg_pkg::word_t y11;
  ecg_pkg::word_t bd;
  ecg_pkg::word_t el_num;
  ecg_pkg::word_t el_mag;
  ecg_pkg::word_t el_rem;
  ecg_pkg::word_t ex_arg;
  ecg_pkg::word_t ffv;
  ecg_pkg::word_t bv;
  ecg_pkg::word_t rmag;
  ecg_pkg::word_t rval;
  logic [1:0] br_c;
  logic lo;

  always_comb begin
    dur_eff = (cycle_duration == 32'd0) ? 32'd1 : cycle_duration;
    sum     = {1'b0, elapsed} + {2'b0, s_tdata};
    x       = {9'b0, t, 14'b0};
    lo      = x < ecg_pkg::W_HALF;
    v       = x <<< 1;
    u       = ecg_pkg::W_TWO - v;
    base    = lo ? v : u;
    // exponent of the 2^-e term, same magnitude on both halves
    ex_arg  = lo ? ecg_pkg::W_TEN - ((x <<< 4) + (x <<< 2))
                 : ((x <<< 4) + (x <<< 2)) - ecg_pkg::W_TEN;
    // elastic phase numerator, later divided by nine
    el_num  = (x <<< 7) + (x <<< 5) - ecg_pkg::W_89;
    el_mag  = el_num[ecg_pkg::WORD_BITS-1] ? -el_num : el_num;
    // remainder of the trial quotient against nine
    el_rem  = el_mag - ((acc <<< 3) + acc);
    // bounce: pick the parabola segment by 11y against 4, 8 and 10
    y       = lo ? ecg_pkg::W_ONE - v : v - ecg_pkg::W_ONE;
    y11     = (y <<< 3) + (y <<< 1) + y;
    if (y11 < (ecg_pkg::W_ONE <<< 2)) begin
      br_c = 2'd0;
      bd   = y11;
    end else if (y11 < (ecg_pkg::W_ONE <<< 3)) begin
      br_c = 2'd1;
      bd   = y11 - ecg_pkg::word_t'(ecg_pkg::W_ONE * 6);
    end else if (y11 < ecg_pkg::W_TEN) begin
      br_c = 2'd2;
      bd   = y11 - ecg_pkg::word_t'(ecg_pkg::W_ONE * 9);
    end else begin
      br_c = 2'd3;
      bd   = (y11 <<< 1) - ecg_pkg::word_t'(ecg_pkg::W_ONE * 21);
    end
    // quarter-wave fold of the sine angle
    ffv = arg[30] ? ecg_pkg::W_ONE - {10'b0, arg[29:0]} : {10'b0, arg[29:0]};
    // bounce segment value from the squared offset
    case (br)
      2'd0:    bv = prod >>> 4;
      2'd1:    bv = (prod >>> 4) + ecg_pkg::word_t'(3 * (ecg_pkg::W_ONE / 4));
      2'd2:    bv = (prod >>> 4) + ecg_pkg::word_t'(15 * (ecg_pkg::W_ONE / 16));
      default: bv = (prod >>> 6) + ecg_pkg::word_t'(63 * (ecg_pkg::W_ONE / 64));
    endcase
    // round q30 to q16, half away from zero
    rmag = ((acc[ecg_pkg::WORD_BITS-1] ? -acc : acc) + 40'sd8192) >>> 14;
    rval = acc[ecg_pkg::WORD_BITS-1] ? -rmag : rmag;
  end

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PW_MUL: begin
        mul_a = acc;
        mul_b = base;
      end
      S_SN_F2: begin
        mul_a = ffv;
        mul_b = ffv;
      end
      S_SN_MUL, S_PX_MUL, S_PX_LAST: begin
        mul_a = acc;
        mul_b = aux;
      end
      S_SN_LAST: begin
        mul_a = acc;
        mul_b = {9'b0, ff};
      end
      S_CI_MUL, S_BK_SQ: begin
        mul_a = base;
        mul_b = base;
      end
      S_BK_M: begin
        mul_a = ecg_pkg::BACK_C2P1;
        mul_b = base;
      end
      S_BK_MUL: begin
        mul_a = aux;
        mul_b = acc;
      end
      S_BO_MUL: begin
        mul_a = bd;
        mul_b = bd;
      end
      S_EL_MUL: begin
        mul_a = pres;
        mul_b = sres;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider and square-root starts
  always_comb begin
    div_req = '0;
    sq_req  = '0;
    if (state == S_NORM && elapsed < {1'b0, dur_eff}) begin
      div_req.start   = 1'b1;
      div_req.rem     = elapsed[31:0];
      div_req.divisor = dur_eff;
      div_req.steps   = 6'(ecg_pkg::FRAC_BITS);
    end
    if (state == S_CI_SQ) begin
      sq_req.start    = 1'b1;
      sq_req.radicand = 31'(ecg_pkg::W_ONE - prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ret            <= S_IDLE;
      easing_mode    <= ecg_pkg::MODE_LINEAR;
      cycle_duration <= 32'd1000;
      elapsed        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // register writes land only while the block is idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ecg_pkg::CFG_EASING_MODE:    easing_mode    <= cfg_data[3:0];
          ecg_pkg::CFG_CYCLE_DURATION: cycle_duration <= cfg_data;
          default: ;
        endcase
      end
      // the output step reloads the register itself
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // add the step, saturating at the top of the 33-bit range
            elapsed <= sum[33] ? '1 : sum[32:0];
            state   <= S_WRAP;
          end
        end
        S_WRAP: begin
          // wrap once only; a large step may leave it past the end
          if (elapsed > {1'b0, dur_eff}) begin
            elapsed <= elapsed - {1'b0, dur_eff};
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (elapsed >= {1'b0, dur_eff}) begin
            t     <= 17'h10000;
            state <= S_EASE;
          end else begin
            state <= S_NORM_WAIT;
          end
        end
        S_NORM_WAIT: begin
          if (div_rsp.done) begin
            t     <= {1'b0, div_rsp.quot[15:0]};
            state <= S_EASE;
          end
        end
        S_EASE: begin
          case (easing_mode)
            ecg_pkg::MODE_LINEAR: begin
              acc   <= x;
              state <= S_ROUND;
            end
            ecg_pkg::MODE_SINE: begin
              arg   <= v + ecg_pkg::W_ONE;
              ret   <= S_SINE_END;
              state <= S_SN_F2;
            end
            ecg_pkg::MODE_QUAD, ecg_pkg::MODE_CUBIC,
            ecg_pkg::MODE_QUART, ecg_pkg::MODE_QUINT: begin
              acc   <= base;
              cnt   <= easing_mode[2:0] - 3'd1;
              state <= S_PW_MUL;
            end
            ecg_pkg::MODE_EXPO: begin
              if (x == '0) begin
                acc   <= '0;
                state <= S_ROUND;
              end else if (x == ecg_pkg::W_ONE) begin
                acc   <= ecg_pkg::W_ONE;
                state <= S_ROUND;
              end else begin
                arg   <= ex_arg;
                ret   <= S_EX_END;
                state <= S_PX_INIT;
              end
            end
            ecg_pkg::MODE_CIRC: begin
              state <= S_CI_MUL;
            end
            ecg_pkg::MODE_BACK: begin
              state <= S_BK_SQ;
            end
            ecg_pkg::MODE_ELASTIC: begin
              if (x == '0) begin
                acc   <= '0;
                state <= S_ROUND;
              end else if (x == ecg_pkg::W_ONE) begin
                acc   <= ecg_pkg::W_ONE;
                state <= S_ROUND;
              end else begin
                state <= S_EL_DIV;
              end
            end
            ecg_pkg::MODE_BOUNCE: begin
              state <= S_BO_MUL;
            end
            default: begin
              acc   <= '0;
              state <= S_ROUND;
            end
          endcase
        end

        // integer powers of the folded time
        S_PW_MUL: begin
          state <= S_PW_ACC;
        end
        S_PW_ACC: begin
          acc <= prod;
          cnt <= cnt - 3'd1;
          state <= (cnt == 3'd1) ? S_PW_END : S_PW_MUL;
        end
        S_PW_END: begin
          acc   <= lo ? ecg_pkg::sdiv2(acc)
                      : ecg_pkg::W_ONE - ecg_pkg::sdiv2(acc);
          state <= S_ROUND;
        end

        // sine of an angle in quarter turns, horner on f^2
        S_SN_F2: begin
          ff    <= ffv[30:0];
          quad  <= arg[31:30];
          state <= S_SN_INIT;
        end
        S_SN_INIT: begin
          aux   <= prod;
          acc   <= ecg_pkg::sin_coef(3'd4);
          cnt   <= 3'd3;
          state <= S_SN_MUL;
        end
        S_SN_MUL: begin
          state <= S_SN_ACC;
        end
        S_SN_ACC: begin
          acc <= ecg_pkg::sin_coef(cnt) - prod;
          if (cnt == 3'd0) begin
            state <= S_SN_LAST;
          end else begin
            cnt   <= cnt - 3'd1;
            state <= S_SN_MUL;
          end
        end
        S_SN_LAST: begin
          state <= S_SN_END;
        end
        S_SN_END: begin
          if (prod > ecg_pkg::W_ONE) begin
            sres <= quad[1] ? -ecg_pkg::W_ONE : ecg_pkg::W_ONE;
          end else begin
            sres <= quad[1] ? -prod : prod;
          end
          state <= ret;
        end
        S_SINE_END: begin
          acc   <= ecg_pkg::sdiv2(ecg_pkg::W_ONE - sres);
          state <= S_ROUND;
        end

        // 2^-e: shift by the integer part, polynomial on the fraction
        S_PX_INIT: begin
          if (arg[39:30] >= 10'd40) begin
            pres  <= '0;
            state <= ret;
          end else if (arg[29:0] == 30'd0) begin
            pres  <= ecg_pkg::W_ONE >>> arg[39:30];
            state <= ret;
          end else begin
            aux   <= ecg_pkg::W_ONE - {10'b0, arg[29:0]};
            acc   <= ecg_pkg::exp_coef(3'd6);
            cnt   <= 3'd5;
            pn    <= arg[35:30];
            state <= S_PX_MUL;
          end
        end
        S_PX_MUL: begin
          state <= S_PX_ACC;
        end
        S_PX_ACC: begin
          acc <= ecg_pkg::exp_coef(cnt) + prod;
          if (cnt == 3'd0) begin
            state <= S_PX_LAST;
          end else begin
            cnt   <= cnt - 3'd1;
            state <= S_PX_MUL;
          end
        end
        S_PX_LAST: begin
          state <= S_PX_END;
        end
        S_PX_END: begin
          pres  <= (ecg_pkg::W_ONE + prod) >>> ({1'b0, pn} + 7'd1);
          state <= ret;
        end
        S_EX_END: begin
          acc   <= lo ? ecg_pkg::sdiv2(pres)
                      : ecg_pkg::sdiv2(ecg_pkg::W_TWO - pres);
          state <= S_ROUND;
        end

        // circular: root of one minus the folded square
        S_CI_MUL: begin
          state <= S_CI_SQ;
        end
        S_CI_SQ: begin
          state <= S_CI_WAIT;
        end
        S_CI_WAIT: begin
          if (sq_rsp.done) begin
            acc   <= lo ? ecg_pkg::sdiv2(ecg_pkg::W_ONE - {9'b0, sq_rsp.root})
                        : ecg_pkg::sdiv2({9'b0, sq_rsp.root} + ecg_pkg::W_ONE);
            state <= S_ROUND;
          end
        end

        // back: square times a linear term with overshoot
        S_BK_SQ: begin
          state <= S_BK_M;
        end
        S_BK_M: begin
          aux   <= prod;
          state <= S_BK_K;
        end
        S_BK_K: begin
          acc   <= lo ? prod - ecg_pkg::BACK_C2 : ecg_pkg::BACK_C2 - prod;
          state <= S_BK_MUL;
        end
        S_BK_MUL: begin
          state <= S_BK_END;
        end
        S_BK_END: begin
          acc   <= lo ? ecg_pkg::sdiv2(prod)
                      : ecg_pkg::W_ONE + ecg_pkg::sdiv2(prod);
          state <= S_ROUND;
        end

        // bounce: one parabola segment
        S_BO_MUL: begin
          br    <= br_c;
          state <= S_BO_END;
        end
        S_BO_END: begin
          acc   <= lo ? ecg_pkg::sdiv2(ecg_pkg::W_ONE - bv)
                      : ecg_pkg::sdiv2(ecg_pkg::W_ONE + bv);
          state <= S_ROUND;
        end

        // elastic: phase / 9 by the series 1/9 = 1/8 (1 - 1/8)(1 + 1/64)...,
        // a one-step fix-up, then sine, decay and product
        S_EL_DIV: begin
          el_neg <= el_num[ecg_pkg::WORD_BITS-1];
          aux    <= el_mag - (el_mag >>> 3);
          state  <= S_EL_D1;
        end
        S_EL_D1: begin
          aux   <= aux + (aux >>> 6);
          state <= S_EL_D2;
        end
        S_EL_D2: begin
          aux   <= aux + (aux >>> 12);
          state <= S_EL_D3;
        end
        S_EL_D3: begin
          acc   <= (aux + (aux >>> 24)) >>> 3;
          state <= S_EL_FIX;
        end
        S_EL_FIX: begin
          // trial quotient is within one of the floor
          if (el_rem[ecg_pkg::WORD_BITS-1]) begin
            acc <= acc - 40'sd1;
          end else if (el_rem >= 40'sd9) begin
            acc <= acc + 40'sd1;
          end else begin
            arg   <= el_neg ? -acc : acc;
            ret   <= S_EL_POW;
            state <= S_SN_F2;
          end
        end
        S_EL_POW: begin
          arg   <= ex_arg;
          ret   <= S_EL_MUL;
          state <= S_PX_INIT;
        end
        S_EL_MUL: begin
          state <= S_EL_END;
        end
        S_EL_END: begin
          acc   <= lo ? -ecg_pkg::sdiv2(prod)
                      : ecg_pkg::sdiv2(prod) + ecg_pkg::W_ONE;
          state <= S_ROUND;
        end

        // round, saturate to q2.16, then hand over to the output register
        S_ROUND: begin
          if (rval > 40'sd131071) begin
            rounded <= 18'h1FFFF;
          end else if (rval < -40'sd131072) begin
            rounded <= 18'h20000;
          end else begin
            rounded <= rval[17:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_prog <= rounded;
            out_norm <= t;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign m_tdata   = {5'b0, out_norm, out_prog};

  // one item in flight: no transfer on the cycle after an accepted one
  `ECG_ASSERT_NEXT(a_single_item, clk, rst, s_tvalid && s_tready, !s_tready)
  // shared units are quiet whenever a new item may be taken
  `ECG_ASSERT_IMPL(a_units_idle, clk, rst, s_tready, !div_rsp.busy && !sq_rsp.busy)
  // normalised time never passes 1.0
  `ECG_ASSERT_IMPL(a_norm_range, clk, rst, m_tvalid, out_norm <= 17'h10000)

endmodule

[sim/easing_curve_generator_tb.sv]
// ----------------------------------------------------------------------------
// easing curve generator testbench
// drives time steps under several curve and duration settings, predicts the
// eased progress and normalised time of every transfer and checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class progress_scoreboard;
  localparam longint ONE = 64'sd1 << 30;
  localparam longint HALF = 64'sd1 << 29;

  logic [3:0]  curve;
  logic [31:0] duration;
  logic [32:0] elapsed;
  logic [17:0] want_progress[$];
  logic [16:0] want_time[$];
  int          n_bad;
  int          n_checked;

  function new();
    curve = ecg_pkg::MODE_LINEAR;
    duration = 32'd1000;
    elapsed = '0;
    n_bad = 0;
    n_checked = 0;
  endfunction

  function automatic longint magnitude(longint a);
    return a < 0 ? -a : a;
  endfunction

  // q30 product of magnitudes, truncated, sign put back
  function automatic longint qmul(longint a, longint b);
    longint m;
    m = longint'(64'(unsigned'(magnitude(a)) * unsigned'(magnitude(b))) >> 30);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint qpow(longint v, int n);
    longint r;
    r = v;
    for (int i = 1; i < n; i++) r = qmul(r, v);
    return r;
  endfunction

  function automatic longint quarter_wave(longint f);
    longint sk[5];
    longint f2, p;
    sk = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272};
    f2 = (f * f) >>> 30;
    p = sk[4];
    for (int i = 3; i >= 0; i--) p = sk[i] - ((p * f2) >>> 30);
    p = (p * f) >>> 30;
    return p > ONE ? ONE : p;
  endfunction

  // angle in q30 quarter turns
  function automatic longint sine_turns(longint q);
    longint r, quad, f, s;
    r = q & (4 * ONE - 1);
    quad = r >>> 30;
    f = r & (ONE - 1);
    s = quarter_wave(quad[0] ? ONE - f : f);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint exp2_neg(longint e);
    longint ek[7];
    longint n, f, g, p;
    ek = '{64'd744261118, 64'd257941248, 64'd59597083, 64'd10327387,
           64'd1431680, 64'd165394, 64'd16377};
    n = e >>> 30;
    f = e & (ONE - 1);
    if (n >= 40) return 0;
    if (f == 0) return ONE >>> n;
    g = ONE - f;
    p = ek[6];
    for (int i = 5; i >= 0; i--) p = ek[i] + ((p * g) >>> 30);
    p = ONE + ((p * g) >>> 30);
    return p >>> (n + 1);
  endfunction

  function automatic longint root_q30(longint a);
    logic [63:0] v, res, b;
    v = (a < 0 ? 64'd0 : 64'(a)) << 30;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint bounce_tail(longint y);
    longint d;
    if (11 * y < 4 * ONE) return qmul(11 * y, 11 * y) / 16;
    if (11 * y < 8 * ONE) begin
      d = 11 * y - 6 * ONE;
      return qmul(d, d) / 16 + 3 * (ONE / 4);
    end
    if (11 * y < 10 * ONE) begin
      d = 11 * y - 9 * ONE;
      return qmul(d, d) / 16 + 15 * (ONE / 16);
    end
    d = 22 * y - 21 * ONE;
    return qmul(d, d) / 64 + 63 * (ONE / 64);
  endfunction

  function automatic longint eased(logic [3:0] m, longint x);
    longint c2, c2p1, v, u, s, sq;
    bit lo;
    c2 = 64'd2786262860;
    c2p1 = 64'd3860004684;
    lo = x < HALF;
    v = 2 * x;
    u = 2 * ONE - 2 * x;
    case (m)
      ecg_pkg::MODE_LINEAR: return x;
      ecg_pkg::MODE_SINE: return (ONE - sine_turns(2 * x + ONE)) / 2;
      ecg_pkg::MODE_QUAD, ecg_pkg::MODE_CUBIC, ecg_pkg::MODE_QUART,
      ecg_pkg::MODE_QUINT:
        return lo ? qpow(v, int'(m)) / 2 : ONE - qpow(u, int'(m)) / 2;
      ecg_pkg::MODE_EXPO: begin
        if (x == 0) return 0;
        if (x == ONE) return ONE;
        return lo ? exp2_neg(10 * ONE - 20 * x) / 2
                  : (2 * ONE - exp2_neg(20 * x - 10 * ONE)) / 2;
      end
      ecg_pkg::MODE_CIRC:
        return lo ? (ONE - root_q30(ONE - qmul(v, v))) / 2
                  : (root_q30(ONE - qmul(u, u)) + ONE) / 2;
      ecg_pkg::MODE_BACK: begin
        if (lo) return qmul(qmul(v, v), qmul(c2p1, v) - c2) / 2;
        sq = qmul(u, u);
        return ONE + qmul(sq, c2 - qmul(c2p1, u)) / 2;
      end
      ecg_pkg::MODE_ELASTIC: begin
        if (x == 0) return 0;
        if (x == ONE) return ONE;
        s = sine_turns((160 * x - 89 * ONE) / 9);
        return lo ? -(qmul(exp2_neg(10 * ONE - 20 * x), s) / 2)
                  : qmul(exp2_neg(20 * x - 10 * ONE), s) / 2 + ONE;
      end
      ecg_pkg::MODE_BOUNCE:
        return lo ? (ONE - bounce_tail(ONE - v)) / 2
                  : (ONE + bounce_tail(v - ONE)) / 2;
      default: return 0;
    endcase
  endfunction

  // advance elapsed time and queue the expected result
  function void note_step(logic [31:0] step);
    logic [33:0] sum;
    logic [32:0] d, r;
    logic [16:0] t;
    longint p, mag;
    d = (duration == 0) ? 33'd1 : {1'b0, duration};
    sum = {1'b0, elapsed} + step;
    if (sum > 34'h1_FFFF_FFFF) sum = 34'h1_FFFF_FFFF;
    if (sum > d) sum -= d;
    elapsed = sum[32:0];
    if (elapsed >= d) begin
      t = 17'h10000;
    end else begin
      t = 0;
      r = elapsed;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        t = t << 1;
        if (r >= d) begin
          r -= d;
          t[0] = 1'b1;
        end
      end
    end
    p = eased(curve, longint'(t) << 14);
    mag = (magnitude(p) + (64'sd1 << 13)) >>> 14;
    p = p < 0 ? -mag : mag;
    if (p > 131071) p = 131071;
    if (p < -131072) p = -131072;
    want_progress.push_back(18'(p));
    want_time.push_back(t);
  endfunction

  function void check_result(logic [39:0] data);
    logic [17:0] ep;
    logic [16:0] et;
    n_checked++;
    if (want_progress.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("unexpected result transfer %h", data);
      return;
    end
    ep = want_progress.pop_front();
    et = want_time.pop_front();
    if (data[17:0] !== ep || data[34:18] !== et || data[39:35] !== 5'd0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch mode %0d: progress exp %h got %h, time exp %h got %h",
                 curve, ep, data[17:0], et, data[34:18]);
    end
  endfunction
endclass

module easing_curve_generator_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [ecg_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  progress_scoreboard board = new();
  bit   hold_off = 1'b0;
  bit   sink_slow = 1'b0;
  int   n_sent = 0;

  always #5 clk = ~clk;

  easing_curve_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mostly short gaps with the odd long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // result side: random back-pressure, plus one long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      g = sink_slow ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [ecg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ecg_pkg::CFG_EASING_MODE) board.curve = val[3:0];
    else board.duration = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one time-step transfer; valid stays high into the next item
  task automatic send_step(logic [31:0] step, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= step;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_step(step);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.want_progress.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // random step: mostly fractions of the duration, sometimes huge
  function automatic logic [31:0] pick_step(logic [31:0] d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return d < 16 ? $urandom_range(0, 20) : $urandom_range(0, d / 4);
    if (r < 85) return $urandom_range(0, 3);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] dur[6];
    logic [31:0] d;
    dur = '{32'd1000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd100000, 32'd37};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, then every curve across the range
    send_step(32'd0, 0);
    send_step(32'd500, 0);
    send_step(32'd500, 0);
    send_step(32'hFFFF_FFFF, 0);
    send_step(32'hFFFF_FFFF, 0);
    drain();
    write_reg(ecg_pkg::CFG_CYCLE_DURATION, 32'd16);
    for (int m = 0; m < 16; m++) begin
      write_reg(ecg_pkg::CFG_EASING_MODE, 4'(m));
      send_step(32'd0, 0);
      send_step(32'd4, 0);
      send_step(32'd4, 0);
      send_step(32'd7, 0);
      send_step(32'd1, 0);
      drain();
    end

    // random phases under several settings
    sink_slow = 1'b1;
    for (int ph = 0; ph < 22; ph++) begin
      d = (ph < 6) ? dur[ph] : ((ph % 3 == 0) ? $urandom : $urandom_range(1, 5000));
      write_reg(ecg_pkg::CFG_CYCLE_DURATION, d);
      write_reg(ecg_pkg::CFG_EASING_MODE,
                (ph < 16) ? 4'(ph) : 4'($urandom_range(0, 15)));
      if (ph == 4) hold_off = 1'b1;
      for (int i = 0; i < 45; i++) begin
        send_step(pick_step(d), ph != 4);
        if (i == 20) drain();
      end
      drain();
    end

    $display("covered %0d time steps over all sixteen curve codes and duration extremes,",
             n_sent);
    $display("with back-pressure, a long receiver hold-off and wrap and saturation cases");
    if (board.n_bad == 0 && board.want_progress.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d left over", board.n_bad, board.want_progress.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
